>>> design/assert_macros.svh
// Assertion helpers shared by the design files.
// Every check is sampled on the rising edge of clk and is switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A concurrent check that reports through $error when it fails.
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A same-cycle implication: whenever cond holds, expr must hold too.
`define CHK_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

`endif

>>> design/nsrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsrb_pkg
// Types, constants and the division step function for the NTP response builder.
// ----------------------------------------------------------------------------
package nsrb_pkg;

  localparam logic [15:0] MIN_PACKET_BYTES = 16'd48;
  localparam logic [2:0]  MODE_CLIENT      = 3'd3;
  localparam logic [2:0]  MODE_SERVER      = 3'd4;
  localparam logic [2:0]  VER_MIN          = 3'd3;
  localparam logic [2:0]  VER_MAX          = 3'd4;
  localparam logic [1:0]  LEAP_ALARM       = 2'd3;
  localparam logic [31:0] UNIX_TO_NTP_SECONDS = 32'd2208988800;
  localparam logic [20:0] MAX_DISPERSION   = 21'd1048576;
  localparam logic [20:0] DISP_FLOOR       = 21'd2;
  localparam logic [19:0] DISP_DIVISOR     = 20'd1017033;
  // ceil(2^51 / DISP_DIVISOR): a 31-bit value times this, shifted right by 51,
  // gives the exact quotient by DISP_DIVISOR.
  localparam logic [31:0] DISP_RECIP       = 32'd2214087266;

  // Dividend bits consumed per pipeline stage, and the number of stages.
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = 24;

  // Time lane: the 96-bit dividend is {0, elapsed, 32 zero bits}, so the
  // low 64 quotient bits are the whole seconds and the fraction together.
  typedef struct packed {
    logic [95:0] dvd;
    logic [31:0] rem;
    logic [63:0] quo;
  } lane_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic        synced;
    logic [7:0]  poll;
    logic [63:0] orig;
    logic [31:0] epoch;
    logic [31:0] divisor;
    lane_t       rx;
    lane_t       tx;
    logic [30:0] since;
  } pipe_t;

  function automatic lane_t lane_step(input lane_t l, input logic [31:0] d);
    logic [32:0] t;
    lane_t       r;
    r     = l;
    t     = {r.rem, r.dvd[95]};
    r.dvd = {r.dvd[94:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t     = t - {1'b0, d};
      r.quo = {r.quo[62:0], 1'b1};
    end else begin
      r.quo = {r.quo[62:0], 1'b0};
    end
    r.rem = t[31:0];
    return r;
  endfunction

endpackage

>>> design/ntp_server_response_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_server_response_builder
// NTP server reply builder with a pipelined long divider for time conversion.
// ----------------------------------------------------------------------------
// A request transfer may be offered in every cycle and the block sustains one
// request per cycle while not stalled. Each accepted request that is long
// enough and in client mode yields one reply transfer after one decode stage,
// 24 divider stages that each resolve four quotient bits of the 96-step
// restoring division of elapsed microseconds by the calibrated interval, and
// one output register, which also forms the root dispersion by a reciprocal
// multiply. Dropped requests leave a bubble and give no reply. A stall on the
// reply side holds the whole pipeline and is passed back to in_stall.
`include "assert_macros.svh"

module ntp_server_response_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] packet_length,
  input  logic [7:0]  request_flags,
  input  logic [7:0]  poll_in,
  input  logic [63:0] client_transmit_time,
  input  logic [62:0] receive_time_us,
  input  logic [62:0] transmit_time_us,
  input  logic [62:0] pps_time_us,
  input  logic [31:0] us_per_second,
  input  logic [31:0] epoch_seconds,
  input  logic        time_valid,
  input  logic [1:0]  leap_indicator,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  response_flags,
  output logic        stratum,
  output logic [7:0]  poll_out,
  output logic [20:0] root_dispersion,
  output logic [31:0] reference_seconds,
  output logic [31:0] receive_seconds,
  output logic [31:0] receive_fraction,
  output logic [31:0] transmit_seconds,
  output logic [31:0] transmit_fraction,
  output logic [63:0] originate_timestamp
);

  logic            en;
  logic            stage_valid [nsrb_pkg::DIV_STAGES+1];
  nsrb_pkg::pipe_t stage_data  [nsrb_pkg::DIV_STAGES+1];
  nsrb_pkg::pipe_t last;
  logic [31:0]     base_sec;
  logic [62:0]     disp_prod;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  nsrb_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .en                   (en),
    .in_valid             (in_valid),
    .packet_length        (packet_length),
    .request_flags        (request_flags),
    .poll_in              (poll_in),
    .client_transmit_time (client_transmit_time),
    .receive_time_us      (receive_time_us),
    .transmit_time_us     (transmit_time_us),
    .pps_time_us          (pps_time_us),
    .us_per_second        (us_per_second),
    .epoch_seconds        (epoch_seconds),
    .time_valid           (time_valid),
    .leap_indicator       (leap_indicator),
    .valid                (stage_valid[0]),
    .data                 (stage_data[0])
  );

  for (genvar g = 0; g < nsrb_pkg::DIV_STAGES; g++) begin : g_div
    nsrb_div_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (stage_valid[g]),
      .prev       (stage_data[g]),
      .valid      (stage_valid[g+1]),
      .data       (stage_data[g+1])
    );
  end

  assign last     = stage_data[nsrb_pkg::DIV_STAGES];
  assign base_sec = last.epoch + nsrb_pkg::UNIX_TO_NTP_SECONDS;
  // Bits 62:51 of the product are the time since sync over the dispersion divisor.
  assign disp_prod = {32'd0, last.since} * {31'd0, nsrb_pkg::DISP_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= stage_valid[nsrb_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      response_flags      <= last.flags;
      stratum             <= last.synced;
      poll_out            <= last.poll;
      originate_timestamp <= last.orig;
      if (last.synced) begin
        root_dispersion   <= {9'd0, disp_prod[62:51]} + nsrb_pkg::DISP_FLOOR;
        reference_seconds <= base_sec;
        receive_seconds   <= base_sec + last.rx.quo[63:32];
        receive_fraction  <= last.rx.quo[31:0];
        transmit_seconds  <= base_sec + last.tx.quo[63:32];
        transmit_fraction <= last.tx.quo[31:0];
      end else begin
        root_dispersion   <= nsrb_pkg::MAX_DISPERSION;
        reference_seconds <= '0;
        receive_seconds   <= '0;
        receive_fraction  <= '0;
        transmit_seconds  <= '0;
        transmit_fraction <= '0;
      end
    end
  end

  `CHK_PROP(a_server_mode, out_valid |-> (response_flags[2:0] == nsrb_pkg::MODE_SERVER &&
            (response_flags[5:3] == nsrb_pkg::VER_MIN || response_flags[5:3] == nsrb_pkg::VER_MAX)),
            "reply is not server mode with version 3 or 4")
  `CHK_IMPL(a_unsync_fields, out_valid && !stratum, (response_flags[7:6] == nsrb_pkg::LEAP_ALARM &&
            root_dispersion == nsrb_pkg::MAX_DISPERSION && receive_fraction == 32'd0),
            "unsynchronised reply carries time data")
  `CHK_IMPL(a_sync_disp, out_valid && stratum, root_dispersion < 21'd2114,
            "synchronised dispersion out of range")

endmodule

>>> design/nsrb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsrb_front
// Request filter and decode stage: checks length and mode, builds the reply
// flags and loads the divider lanes with the elapsed times.
// ----------------------------------------------------------------------------
module nsrb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [15:0]          packet_length,
  input  logic [7:0]           request_flags,
  input  logic [7:0]           poll_in,
  input  logic [63:0]          client_transmit_time,
  input  logic [62:0]          receive_time_us,
  input  logic [62:0]          transmit_time_us,
  input  logic [62:0]          pps_time_us,
  input  logic [31:0]          us_per_second,
  input  logic [31:0]          epoch_seconds,
  input  logic                 time_valid,
  input  logic [1:0]           leap_indicator,
  output logic                 valid,
  output nsrb_pkg::pipe_t      data
);

  logic            keep;
  logic [2:0]      ver;
  logic [1:0]      li;
  logic [62:0]     rx_el;
  logic [62:0]     tx_el;
  logic [30:0]     since;
  nsrb_pkg::pipe_t data_next;

  always_comb begin
    keep = (packet_length >= nsrb_pkg::MIN_PACKET_BYTES) &&
           (request_flags[2:0] == nsrb_pkg::MODE_CLIENT);
    ver = request_flags[5:3];
    if (ver < nsrb_pkg::VER_MIN) begin
      ver = nsrb_pkg::VER_MIN;
    end else if (ver > nsrb_pkg::VER_MAX) begin
      ver = nsrb_pkg::VER_MAX;
    end
    li = time_valid ? leap_indicator : nsrb_pkg::LEAP_ALARM;
    // A local time before the PPS edge counts as no time elapsed.
    rx_el = (receive_time_us > pps_time_us) ? (receive_time_us - pps_time_us) : 63'd0;
    tx_el = (transmit_time_us > pps_time_us) ? (transmit_time_us - pps_time_us) : 63'd0;
    since = receive_time_us[30:0] - pps_time_us[30:0];

    data_next.flags   = {li, ver, nsrb_pkg::MODE_SERVER};
    data_next.synced  = time_valid;
    data_next.poll    = poll_in;
    data_next.orig    = client_transmit_time;
    data_next.epoch   = epoch_seconds;
    data_next.divisor = (us_per_second == 32'd0) ? 32'd1 : us_per_second;
    data_next.rx.dvd  = {1'b0, rx_el, 32'd0};
    data_next.rx.rem  = '0;
    data_next.rx.quo  = '0;
    data_next.tx.dvd  = {1'b0, tx_el, 32'd0};
    data_next.tx.rem  = '0;
    data_next.tx.quo  = '0;
    data_next.since   = since;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

>>> design/nsrb_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsrb_div_stage
// One register stage of the restoring dividers: four quotient bits each for the
// receive lane and the transmit lane.
// ----------------------------------------------------------------------------
module nsrb_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            prev_valid,
  input  nsrb_pkg::pipe_t prev,
  output logic            valid,
  output nsrb_pkg::pipe_t data
);

  nsrb_pkg::pipe_t data_next;

  always_comb begin
    data_next = prev;
    for (int i = 0; i < nsrb_pkg::STEPS_PER_STAGE; i++) begin
      data_next.rx   = nsrb_pkg::lane_step(data_next.rx, prev.divisor);
      data_next.tx   = nsrb_pkg::lane_step(data_next.tx, prev.divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule
